[hdl/c8x_pkg.sv]
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared types and constants of the CHIP-8 instruction execute unit.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int REG_COUNT   = 16;
  localparam int REG_AW      = $clog2(REG_COUNT);
  localparam int ADDR_W      = 12;

  localparam logic [ADDR_W-1:0] PC_RESET  = 12'h200;
  localparam logic [REG_AW-1:0] FLAG_REG  = 4'hF;
  localparam logic [15:0]       OPC_CLS   = 16'h00E0;
  localparam logic [15:0]       OPC_RET   = 16'h00EE;
  localparam logic [7:0]        KK_LD_VX_DT = 8'h07;
  localparam logic [7:0]        KK_LD_DT_VX = 8'h15;

  // Top nibble of the instruction word
  typedef enum logic [3:0] {
    OP_SYS   = 4'h0,
    OP_JP    = 4'h1,
    OP_CALL  = 4'h2,
    OP_SE_K  = 4'h3,
    OP_SNE_K = 4'h4,
    OP_SE_V  = 4'h5,
    OP_LD_K  = 4'h6,
    OP_ADD_K = 4'h7,
    OP_ALU   = 4'h8,
    OP_SNE_V = 4'h9,
    OP_LD_I  = 4'hA,
    OP_JP_V0 = 4'hB,
    OP_RND   = 4'hC,
    OP_DRW   = 4'hD,
    OP_KEY   = 4'hE,
    OP_MISC  = 4'hF
  } op_major_t;

  // Low nibble of 8xyn
  typedef enum logic [3:0] {
    ALU_LD   = 4'h0,
    ALU_OR   = 4'h1,
    ALU_AND  = 4'h2,
    ALU_XOR  = 4'h3,
    ALU_ADD  = 4'h4,
    ALU_SUB  = 4'h5,
    ALU_SHR  = 4'h6,
    ALU_SUBN = 4'h7,
    ALU_SHL  = 4'hE
  } alu_op_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_pc;
    logic              clear_screen;
    logic              draw_request;
    logic [7:0]        draw_x;
    logic [7:0]        draw_y;
    logic [3:0]        draw_rows;
    logic [ADDR_W-1:0] sprite_address;
    logic              stack_fault;
    logic              unknown_opcode;
  } out_item_t;

  // State updates and result of one executed instruction
  typedef struct packed {
    logic              vx_we;
    logic [7:0]        vx_data;
    logic              vf_we;
    logic [7:0]        vf_data;
    logic              index_we;
    logic              delay_we;
    logic              push;
    logic              pop;
    out_item_t         res;
  } exec_t;

endpackage

[hdl/c8x_in_if.sv]
// ----------------------------------------------------------------------------
// c8x_in_if
// Instruction channel: valid/ready with opcode and random byte.
// ----------------------------------------------------------------------------
interface c8x_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] opcode;
  logic [7:0]  random_byte;

  modport source (output valid, output opcode, output random_byte, input ready);
  modport sink   (input valid, input opcode, input random_byte, output ready);
endinterface

[hdl/c8x_out_if.sv]
// ----------------------------------------------------------------------------
// c8x_out_if
// Result channel: valid/ready with next PC and request flags.
// ----------------------------------------------------------------------------
interface c8x_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] next_pc;
  logic        clear_screen;
  logic        draw_request;
  logic [7:0]  draw_x;
  logic [7:0]  draw_y;
  logic [3:0]  draw_rows;
  logic [11:0] sprite_address;
  logic        stack_fault;
  logic        unknown_opcode;

  modport source (
    output valid, output next_pc, output clear_screen, output draw_request,
    output draw_x, output draw_y, output draw_rows, output sprite_address,
    output stack_fault, output unknown_opcode, input ready
  );
  modport sink (
    input valid, input next_pc, input clear_screen, input draw_request,
    input draw_x, input draw_y, input draw_rows, input sprite_address,
    input stack_fault, input unknown_opcode, output ready
  );
endinterface

[hdl/c8x_regfile.sv]
// ----------------------------------------------------------------------------
// c8x_regfile
// V0-VF: two registered read ports, one write port, write-to-read bypass.
// ----------------------------------------------------------------------------
module c8x_regfile
  import c8x_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              re,
  input  logic [REG_AW-1:0] raddr_a,
  input  logic [REG_AW-1:0] raddr_b,
  output logic [7:0]        rdata_a,
  output logic [7:0]        rdata_b,
  input  logic              we,
  input  logic [REG_AW-1:0] waddr,
  input  logic [7:0]        wdata
);

  logic [7:0]           mem [REG_COUNT];
  logic [REG_COUNT-1:0] written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // unwritten entries read as zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && waddr == raddr_a) begin
        rdata_a <= wdata;
      end else begin
        rdata_a <= written[raddr_a] ? mem[raddr_a] : 8'h00;
      end
      if (we && waddr == raddr_b) begin
        rdata_b <= wdata;
      end else begin
        rdata_b <= written[raddr_b] ? mem[raddr_b] : 8'h00;
      end
    end
  end

endmodule

[hdl/c8x_stack.sv]
// ----------------------------------------------------------------------------
// c8x_stack
// Call stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module c8x_stack
  import c8x_pkg::*;
(
  input  logic                clk,
  input  logic                re,
  input  logic [STACK_AW-1:0] raddr,
  output logic [ADDR_W-1:0]   rdata,
  input  logic                we,
  input  logic [STACK_AW-1:0] waddr,
  input  logic [ADDR_W-1:0]   wdata
);

  logic [ADDR_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/c8x_exec.sv]
// ----------------------------------------------------------------------------
// c8x_exec
// Instruction decode and execute: state updates and result of one opcode.
// ----------------------------------------------------------------------------
module c8x_exec
  import c8x_pkg::*;
(
  input  logic [15:0]        opcode,
  input  logic [7:0]         random_byte,
  input  logic [7:0]         vx,
  input  logic [7:0]         vy,
  input  logic [ADDR_W-1:0]  pc,
  input  logic [ADDR_W-1:0]  index,
  input  logic [7:0]         delay,
  input  logic [LEVEL_W-1:0] level,
  input  logic [ADDR_W-1:0]  stack_top,
  output exec_t              ex
);

  logic [7:0]        kk;
  logic [ADDR_W-1:0] nnn;
  logic [3:0]        n;
  logic [8:0]        sum9;

  assign kk   = opcode[7:0];
  assign nnn  = opcode[11:0];
  assign n    = opcode[3:0];
  assign sum9 = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    logic jump;
    logic skip;
    logic ret_ok;
    ex     = '0;
    jump   = 1'b0;
    skip   = 1'b0;
    ret_ok = 1'b0;
    ex.res.next_pc = nnn;
    unique case (op_major_t'(opcode[15:12]))
      OP_SYS: begin
        if (opcode == OPC_CLS) begin
          ex.res.clear_screen = 1'b1;
        end else if (opcode == OPC_RET) begin
          if (level == '0) begin
            ex.res.stack_fault = 1'b1;
          end else begin
            ex.pop = 1'b1;
            ret_ok = 1'b1;
          end
        end else begin
          ex.res.unknown_opcode = 1'b1;
        end
      end
      OP_JP: jump = 1'b1;
      OP_CALL: begin
        if (level >= LEVEL_W'(STACK_DEPTH)) begin
          ex.res.stack_fault = 1'b1;
        end else begin
          ex.push = 1'b1;
          jump    = 1'b1;
        end
      end
      OP_SE_K:  skip = (vx == kk);
      OP_SNE_K: skip = (vx != kk);
      OP_SE_V:  skip = (vx == vy);
      OP_SNE_V: skip = (vx != vy);
      OP_LD_K: begin
        ex.vx_we = 1'b1;
        ex.vx_data = kk;
      end
      OP_ADD_K: begin
        ex.vx_we = 1'b1;
        ex.vx_data = vx + kk;
      end
      OP_ALU: begin
        ex.vx_we = 1'b1;
        unique case (n)
          ALU_LD:  ex.vx_data = vy;
          ALU_OR:  ex.vx_data = vx | vy;
          ALU_AND: ex.vx_data = vx & vy;
          ALU_XOR: ex.vx_data = vx ^ vy;
          ALU_ADD: begin
            ex.vx_data = sum9[7:0];
            ex.vf_we   = 1'b1;
            ex.vf_data = {7'd0, sum9[8]};
          end
          ALU_SUB: begin
            ex.vx_data = vx - vy;
            ex.vf_we   = 1'b1;
            ex.vf_data = {7'd0, vx > vy};
          end
          ALU_SHR: begin
            ex.vx_data = {1'b0, vx[7:1]};
            ex.vf_we   = 1'b1;
            ex.vf_data = {7'd0, vx[0]};
          end
          ALU_SUBN: begin
            ex.vx_data = vy - vx;
            ex.vf_we   = 1'b1;
            ex.vf_data = {7'd0, vy > vx};
          end
          ALU_SHL: begin
            ex.vx_data = {vx[6:0], 1'b0};
            ex.vf_we   = 1'b1;
            ex.vf_data = {7'd0, vx[7]};
          end
          default: begin
            ex.vx_we = 1'b0;
            ex.res.unknown_opcode = 1'b1;
          end
        endcase
      end
      OP_LD_I: ex.index_we = 1'b1;
      OP_JP_V0: begin
        // the x read port carries V0 for this opcode
        jump = 1'b1;
        ex.res.next_pc = nnn + {4'd0, vx};
      end
      OP_RND: begin
        ex.vx_we = 1'b1;
        ex.vx_data = random_byte & kk;
      end
      OP_DRW: begin
        ex.res.draw_request   = 1'b1;
        ex.res.draw_x         = vx;
        ex.res.draw_y         = vy;
        ex.res.draw_rows      = n;
        ex.res.sprite_address = index;
        ex.vf_we   = 1'b1;
        ex.vf_data = 8'h00;
      end
      OP_KEY: ex.res.unknown_opcode = 1'b1;
      OP_MISC: begin
        if (kk == KK_LD_VX_DT) begin
          ex.vx_we = 1'b1;
          ex.vx_data = delay;
        end else if (kk == KK_LD_DT_VX) begin
          ex.delay_we = 1'b1;
        end else begin
          ex.res.unknown_opcode = 1'b1;
        end
      end
      default: ex.res.unknown_opcode = 1'b1;
    endcase
    if (!jump) begin
      ex.res.next_pc = (ret_ok ? stack_top : pc) + (skip ? 12'd4 : 12'd2);
    end
  end

endmodule

[hdl/chip8_instruction_execute_unit.sv]
// ----------------------------------------------------------------------------
// chip8_instruction_execute_unit
// Executes one CHIP-8 instruction per transaction against V0-VF, I, PC,
// the call stack and the delay timer; returns next PC and request flags.
// ----------------------------------------------------------------------------
//  channel  | modport | payload
//  ---------+---------+--------------------------------------------------
//  in_ch    | sink    | opcode[15:0], random_byte[7:0]
//  out_ch   | source  | next_pc, clear_screen, draw_request, draw_x,
//           |         | draw_y, draw_rows, sprite_address, stack_fault,
//           |         | unknown_opcode
//
// Steps: accept reads Vx/Vy from the register file and the stack top from
//   stack memory; execute then runs the opcode and writes Vx. The VF write
//   lands in the following cycle, which is the next instruction's earliest
//   read cycle; the register file bypasses it to that read.
// Reset: synchronous on rst. V0-VF read as zero through per-entry written
//   bits, so there is no clearing pass; stack contents stay undefined.
// Stalls: results sit in an output register. A new instruction is taken
//   while a result waits; execute holds only if the output register is
//   still full when its result is ready.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_unit
  import c8x_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  c8x_in_if.sink     in_ch,
  c8x_out_if.source  out_ch
);

  // pipeline control
  logic               in_fire;
  logic               ex_valid;
  logic               ex_fire;
  logic               out_valid;
  out_item_t          out_q;

  // instruction held for execute
  logic [15:0]        op_q;
  logic [7:0]         rnd_q;

  // architectural registers outside the memories
  logic [ADDR_W-1:0]  pc;
  logic [ADDR_W-1:0]  index;
  logic [7:0]         delay;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] level_next;
  logic [LEVEL_W-1:0] level_dec;

  // deferred VF write
  logic               vf_pend;
  logic [7:0]         vf_data_q;

  // memory ports
  logic [REG_AW-1:0]  raddr_a;
  logic [7:0]         vx;
  logic [7:0]         vy;
  logic               rf_we;
  logic [REG_AW-1:0]  rf_waddr;
  logic [7:0]         rf_wdata;
  logic [ADDR_W-1:0]  stack_top;

  exec_t              ex;

  assign in_ch.ready = !ex_valid;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign ex_fire     = ex_valid && (!out_valid || out_ch.ready);

  // JP V0 reads V0 on the x port
  assign raddr_a   = (op_major_t'(in_ch.opcode[15:12]) == OP_JP_V0) ? '0
                                                                  : in_ch.opcode[11:8];
  assign level_dec = level - LEVEL_W'(1);

  // Vx write in execute cycle, VF write the cycle after
  assign rf_we    = (ex_fire && ex.vx_we) || vf_pend;
  assign rf_waddr = vf_pend ? FLAG_REG : op_q[11:8];
  assign rf_wdata = vf_pend ? vf_data_q : ex.vx_data;

  c8x_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .re      (in_fire),
    .raddr_a (raddr_a),
    .raddr_b (in_ch.opcode[7:4]),
    .rdata_a (vx),
    .rdata_b (vy),
    .we      (rf_we),
    .waddr   (rf_waddr),
    .wdata   (rf_wdata)
  );

  // read the entry below the level; a wrapped address on an empty stack is
  // never used since RET then faults
  c8x_stack u_stack (
    .clk   (clk),
    .re    (in_fire),
    .raddr (level_dec[STACK_AW-1:0]),
    .rdata (stack_top),
    .we    (ex_fire && ex.push),
    .waddr (level[STACK_AW-1:0]),
    .wdata (pc)
  );

  c8x_exec u_exec (
    .opcode      (op_q),
    .random_byte (rnd_q),
    .vx          (vx),
    .vy          (vy),
    .pc          (pc),
    .index       (index),
    .delay       (delay),
    .level       (level),
    .stack_top   (stack_top),
    .ex          (ex)
  );

  always_comb begin
    level_next = level;
    if (ex.push) begin
      level_next = level + LEVEL_W'(1);
    end else if (ex.pop) begin
      level_next = level_dec;
    end
  end

  // instruction capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q  <= in_ch.opcode;
      rnd_q <= in_ch.random_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (in_fire) begin
      ex_valid <= 1'b1;
    end else if (ex_fire) begin
      ex_valid <= 1'b0;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= PC_RESET;
      index   <= '0;
      delay   <= '0;
      level   <= '0;
      vf_pend <= 1'b0;
    end else begin
      vf_pend <= ex_fire && ex.vf_we;
      if (ex_fire) begin
        pc    <= ex.res.next_pc;
        level <= level_next;
        if (ex.index_we) begin
          index <= op_q[11:0];
        end
        if (ex.delay_we) begin
          delay <= vx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      vf_data_q <= ex.vf_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ex_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      out_q <= ex.res;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.next_pc        = out_q.next_pc;
  assign out_ch.clear_screen   = out_q.clear_screen;
  assign out_ch.draw_request   = out_q.draw_request;
  assign out_ch.draw_x         = out_q.draw_x;
  assign out_ch.draw_y         = out_q.draw_y;
  assign out_ch.draw_rows      = out_q.draw_rows;
  assign out_ch.sprite_address = out_q.sprite_address;
  assign out_ch.stack_fault    = out_q.stack_fault;
  assign out_ch.unknown_opcode = out_q.unknown_opcode;

  // VF write-back never competes with an execute for the write port
  a_vf_port_free: assert property (@(posedge clk) disable iff (rst)
    !(vf_pend && ex_fire))
    else $error("VF write overlaps execute");

  // a pending VF write comes only from the instruction executed just before
  a_vf_after_exec: assert property (@(posedge clk) disable iff (rst)
    vf_pend |-> $past(ex_fire))
    else $error("VF write without preceding execute");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    ex_fire |=> out_valid)
    else $error("executed instruction produced no result");

  // an accepted instruction executes before the next is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> ex_valid && !in_ch.ready)
    else $error("instruction accepted while another is pending");

endmodule
